@@ src/sfr_pkg.sv @@
// Package for the stuffed frame receiver: shared types, codes and the CRC fold.
// Used by stuffed_frame_receiver_crc16; depends on nothing.
package sfr_pkg;

    localparam int MAX_FRAME = 64;
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);
    localparam int IDX_W     = 6;
    localparam int RAW_W     = 7;
    localparam logic [RAW_W-1:0] RAW_SAT   = {RAW_W{1'b1}};
    localparam logic [RAW_W-1:0] RAW_MIN   = RAW_W'(4);
    localparam logic [15:0]      CRC_INIT  = 16'hFFFF;
    localparam logic [15:0]      CRC_POLY  = 16'h1021;
    localparam int               CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_CHAR  = 3'd0,
        CFG_ESCAPE_CHAR = 3'd1,
        CFG_XOR_CHAR    = 3'd2,
        CFG_LEN_MASK    = 3'd3,
        CFG_ADDR_MASK   = 3'd4
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_NO_START = 3'd2,
        ST_LEN      = 3'd3,
        ST_CRC      = 3'd4
    } t_status;

    typedef enum logic {
        KIND_BYTE   = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        byte_value;
        logic [IDX_W-1:0]  byte_index;
        t_status           status;
        logic [7:0]        module_addr;
        logic [7:0]        command;
        logic [IDX_W-1:0]  payload_len;
        logic              last;
    } t_result;

    // Fold one byte into CRC-16/CCITT-FALSE, MSB first.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ src/stuffed_frame_receiver_crc16.sv @@
// Top level of the byte-stuffed frame receiver with CRC-16 check.
// Depends on sfr_pkg for types, codes and the CRC fold.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one raw received byte per
//   request, with i_end_of_chunk high on the last byte of a chunk. The first
//   byte of a chunk must be the start character; escape bytes are dropped and
//   make the next byte be XORed with the xor character.
//   Output channel (o_out_valid / i_out_ready) carries results: a byte item
//   (o_kind 0) per destuffed byte within MAX_FRAME, a status item (o_kind 1) at chunk end.
//   o_last marks the final result caused by one input request.
//   Results are registered; the first appears in the cycle after acceptance.
//   Throughput: one input byte per cycle while the port drains; a byte that
//   yields both a byte item and a status item blocks input until its status item reaches the port.
//   A two-entry result holder feeds the port: a byte is taken only when no
//   second result is queued and the port is empty or drains in that cycle.
//   When the receiver stalls, results hold and input requests back up.
//   Reset (i_rst_n low, synchronous) restores register defaults, clears the
//   frame state and drops any queued result.
//   Configuration writes (i_cfg_wr_en) take effect at once; write only while
//   idle. Indexes beyond the register list are ignored.
module stuffed_frame_receiver_crc16 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_rx_byte,
    input  logic                          i_end_of_chunk,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_kind,
    output logic [7:0]                    o_byte_value,
    output logic [sfr_pkg::IDX_W-1:0]     o_byte_index,
    output logic [2:0]                    o_status,
    output logic [7:0]                    o_module_addr,
    output logic [7:0]                    o_command,
    output logic [sfr_pkg::IDX_W-1:0]     o_payload_len,
    output logic                          o_last
);

    // configuration registers
    logic [7:0] r_start_char, r_escape_char, r_xor_char, r_len_mask, r_addr_mask;

    // frame state
    logic [sfr_pkg::RAW_W-1:0] r_raw, n_raw;
    logic                      r_start, n_start;
    logic                      r_esc, n_esc;
    logic [sfr_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                      r_ovf, n_ovf;
    logic [15:0]               r_crc, n_crc;
    logic [7:0]                r_hdr, n_hdr;
    logic [7:0]                r_cmd, n_cmd;

    // frame state after this byte, before the end-of-chunk clear
    logic [sfr_pkg::RAW_W-1:0] s_raw;
    logic                      s_start, s_esc, s_ovf;
    logic [sfr_pkg::CNT_W-1:0] s_cnt;
    logic [15:0]               s_crc;
    logic [7:0]                s_hdr, s_cmd;

    // result holder: slot 0 drives the port, slot 1 queues behind it
    logic                      r_out_valid, r_pend_valid;
    sfr_pkg::t_result          r_out, r_pend;

    logic                      in_accept, out_take;
    logic                      byte_item;
    logic [7:0]                dvalue;
    logic [9:0]                want_len;
    sfr_pkg::t_status          st;
    sfr_pkg::t_result          byte_res, stat_res;

    // Accept a new byte when nothing is queued and slot 0 is empty or draining.
    assign out_take   = r_out_valid && i_out_ready;
    assign o_in_ready = !r_pend_valid && (!r_out_valid || i_out_ready);
    assign in_accept  = i_in_valid && o_in_ready;

    always_comb begin
        s_raw     = r_raw;
        s_start   = r_start;
        s_esc     = r_esc;
        s_cnt     = r_cnt;
        s_ovf     = r_ovf;
        s_crc     = r_crc;
        s_hdr     = r_hdr;
        s_cmd     = r_cmd;
        byte_item = 1'b0;
        dvalue    = i_rx_byte ^ (r_esc ? r_xor_char : 8'h00);

        if (r_raw == '0) begin
            s_start = (i_rx_byte == r_start_char);
        end else if (r_start) begin
            if (i_rx_byte == r_escape_char) begin
                s_esc = 1'b1;
            end else begin
                s_esc = 1'b0;
                // drop bytes past the frame limit and flag the overflow
                if (r_cnt >= sfr_pkg::CNT_W'(sfr_pkg::MAX_FRAME)) begin
                    s_ovf = 1'b1;
                end else begin
                    byte_item = 1'b1;
                    if (r_cnt == sfr_pkg::CNT_W'(0)) s_hdr = dvalue;
                    if (r_cnt == sfr_pkg::CNT_W'(1)) s_cmd = dvalue;
                    s_crc = sfr_pkg::crc_fold(r_crc, dvalue);
                    s_cnt = r_cnt + sfr_pkg::CNT_W'(1);
                end
            end
        end
        if (r_raw != sfr_pkg::RAW_SAT) begin
            s_raw = r_raw + sfr_pkg::RAW_W'(1);
        end
    end

    // status checks, in priority order
    always_comb begin
        want_len = {1'b0, (s_hdr & r_len_mask), 1'b0} + 10'd4;
        priority if (s_raw < sfr_pkg::RAW_MIN) begin
            st = sfr_pkg::ST_SHORT;
        end else if (!s_start) begin
            st = sfr_pkg::ST_NO_START;
        end else if (s_ovf || (want_len != 10'(s_cnt))) begin
            st = sfr_pkg::ST_LEN;
        end else if (s_crc != 16'h0000) begin
            st = sfr_pkg::ST_CRC;
        end else begin
            st = sfr_pkg::ST_OK;
        end
    end

    always_comb begin
        byte_res             = '0;
        byte_res.kind        = sfr_pkg::KIND_BYTE;
        byte_res.byte_value  = dvalue;
        byte_res.byte_index  = r_cnt[sfr_pkg::IDX_W-1:0];
        byte_res.status      = sfr_pkg::ST_OK;
        byte_res.last        = !i_end_of_chunk;

        stat_res             = '0;
        stat_res.kind        = sfr_pkg::KIND_STATUS;
        stat_res.status      = st;
        stat_res.last        = 1'b1;
        if (st == sfr_pkg::ST_OK || st == sfr_pkg::ST_CRC) begin
            stat_res.module_addr = s_hdr & r_addr_mask;
            stat_res.command     = s_cmd;
            stat_res.payload_len = s_cnt[sfr_pkg::IDX_W-1:0] - sfr_pkg::IDX_W'(4);
        end
    end

    // clear the frame at chunk end
    always_comb begin
        if (i_end_of_chunk) begin
            n_raw   = '0;
            n_start = 1'b0;
            n_esc   = 1'b0;
            n_cnt   = '0;
            n_ovf   = 1'b0;
            n_crc   = sfr_pkg::CRC_INIT;
            n_hdr   = 8'h00;
            n_cmd   = 8'h00;
        end else begin
            n_raw   = s_raw;
            n_start = s_start;
            n_esc   = s_esc;
            n_cnt   = s_cnt;
            n_ovf   = s_ovf;
            n_crc   = s_crc;
            n_hdr   = s_hdr;
            n_cmd   = s_cmd;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_char  <= 8'd126;
            r_escape_char <= 8'd125;
            r_xor_char    <= 8'd32;
            r_len_mask    <= 8'd15;
            r_addr_mask   <= 8'd240;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                sfr_pkg::CFG_START_CHAR:  r_start_char  <= i_cfg_data;
                sfr_pkg::CFG_ESCAPE_CHAR: r_escape_char <= i_cfg_data;
                sfr_pkg::CFG_XOR_CHAR:    r_xor_char    <= i_cfg_data;
                sfr_pkg::CFG_LEN_MASK:    r_len_mask    <= i_cfg_data;
                sfr_pkg::CFG_ADDR_MASK:   r_addr_mask   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw   <= '0;
            r_start <= 1'b0;
            r_esc   <= 1'b0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_crc   <= sfr_pkg::CRC_INIT;
            r_hdr   <= 8'h00;
            r_cmd   <= 8'h00;
        end else if (in_accept) begin
            r_raw   <= n_raw;
            r_start <= n_start;
            r_esc   <= n_esc;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_crc   <= n_crc;
            r_hdr   <= n_hdr;
            r_cmd   <= n_cmd;
        end
    end

    // result holder control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid  <= byte_item || i_end_of_chunk;
            r_pend_valid <= byte_item && i_end_of_chunk;
        end else if (out_take) begin
            // advance the queued result into slot 0
            r_out_valid  <= r_pend_valid;
            r_pend_valid <= 1'b0;
        end
    end

    // result holder payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out  <= byte_item ? byte_res : stat_res;
            r_pend <= stat_res;
        end else if (out_take) begin
            r_out  <= r_pend;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out.kind;
    assign o_byte_value  = r_out.byte_value;
    assign o_byte_index  = r_out.byte_index;
    assign o_status      = r_out.status;
    assign o_module_addr = r_out.module_addr;
    assign o_command     = r_out.command;
    assign o_payload_len = r_out.payload_len;
    assign o_last        = r_out.last;

endmodule
